// ===== rtl/linear_regression_gradient_descent_core_macros.svh =====
// Assertion macros shared by the checker of the regression core.
// Needs nothing else; include with the bare file name.
`ifndef LINEAR_REGRESSION_GRADIENT_DESCENT_CORE_MACROS_SVH
`define LINEAR_REGRESSION_GRADIENT_DESCENT_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LRGD_ASSERT_NOW(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define LRGD_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/lrgd_pkg.sv =====
// Shared types, constants and helpers of the regression core.
// Used by the core, lrgd_ctrl, lrgd_dp and lrgd_div; depends on nothing.
package lrgd_pkg;

  localparam int MAX_SAMPLES_DEF = 4096;
  localparam int X_W    = 17;
  localparam int Y_W    = 32;
  localparam int COEF_W = 32;
  localparam int COST_W = 40;
  localparam int LR_W   = 16;
  localparam int ITER_W = 16;
  localparam int SUM_W  = 64;
  localparam int IDX_W  = 8;

  localparam logic [LR_W-1:0]   LR_RESET   = 16'd11469;
  localparam logic [ITER_W-1:0] ITER_RESET = 16'd1000;

  // Register indexes
  localparam logic [IDX_W-1:0] CFG_LEARNING_RATE     = 8'd0;
  localparam logic [IDX_W-1:0] CFG_ITERATION_COUNT   = 8'd1;
  localparam logic [IDX_W-1:0] CFG_INITIAL_SLOPE     = 8'd2;
  localparam logic [IDX_W-1:0] CFG_INITIAL_INTERCEPT = 8'd3;

  typedef enum logic [2:0] {
    ST_LOAD, ST_SWEEP, ST_DRAIN, ST_DIV, ST_MUL, ST_EMIT
  } ctrl_state_t;

  typedef enum logic [1:0] {
    SEL_SLOPE, SEL_INTERCEPT, SEL_COST
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     init;
    logic     sweep_clr;
    logic     rd_en;
    logic     div_start;
    div_sel_t div_sel;
    logic     mul_start;
    logic     upd_a;
    logic     upd_b;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic rd_last;
    logic pipe_busy;
    logic div_done;
    logic mul_done;
    logic out_busy;
  } stat_t;

  // Clamp a wide signed value to 32 bits
  function automatic logic signed [COEF_W-1:0] sat32(input logic signed [57:0] v);
    logic same;
    same = (&v[57:31]) | ~(|v[57:31]);
    if (same) sat32 = v[31:0];
    else if (v[57]) sat32 = {1'b1, {(COEF_W-1){1'b0}}};
    else sat32 = {1'b0, {(COEF_W-1){1'b1}}};
  endfunction

endpackage

// ===== rtl/linear_regression_gradient_descent_core.sv =====
// Top level of the batch gradient descent regression core.
// Depends on lrgd_pkg, lrgd_ctrl and lrgd_dp.
//
// Usage: send (x, y) words on the in_ stream; in_tlast marks the final
// sample and starts training. Non-final words are taken while the core
// is not training. Samples past MAX_SAMPLES are dropped and reported in
// out_tuser. Training runs iteration_count iterations; each one sweeps
// the N stored samples through the store read port and uses the shared
// divider once per gradient. A final cost pass follows the last one.
// One result word then appears on out_ and holds until taken; the store
// keeps loading the next data set meanwhile, and a new final sample waits
// until the result has gone. Registers are written on cfg_ (always
// ready); the user must write them only while the core is idle, as the
// core does not enforce it. Reset (rst_n low, synchronous) empties the
// store, clears the drop flag and restores the register defaults;
// no clearing pass is needed.
module linear_regression_gradient_descent_core #(
  parameter int MAX_SAMPLES = lrgd_pkg::MAX_SAMPLES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [55:0]  in_tdata,   // [16:0] sample_x, [48:17] sample_y, zero pad
  input  logic         in_tlast,   // last_sample
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [103:0] out_tdata,  // [31:0] slope, [63:32] intercept, [103:64] final_cost
  output logic         out_tuser,  // overflow
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  logic [lrgd_pkg::LR_W-1:0]          lr_r;
  logic [lrgd_pkg::ITER_W-1:0]        iter_r;
  logic signed [lrgd_pkg::COEF_W-1:0] slope0_r, icpt0_r;
  lrgd_pkg::cmd_t  cmd;
  lrgd_pkg::stat_t stat;
  logic signed [lrgd_pkg::COEF_W-1:0] slope, icpt;
  logic [lrgd_pkg::COST_W-1:0]        cost;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r     <= lrgd_pkg::LR_RESET;
      iter_r   <= lrgd_pkg::ITER_RESET;
      slope0_r <= '0;
      icpt0_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        lrgd_pkg::CFG_LEARNING_RATE:     lr_r     <= cfg_data[lrgd_pkg::LR_W-1:0];
        lrgd_pkg::CFG_ITERATION_COUNT:   iter_r   <= cfg_data[lrgd_pkg::ITER_W-1:0];
        lrgd_pkg::CFG_INITIAL_SLOPE:     slope0_r <= cfg_data;
        lrgd_pkg::CFG_INITIAL_INTERCEPT: icpt0_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  lrgd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .iter_cfg  (iter_r),
    .stat      (stat),
    .cmd       (cmd)
  );

  lrgd_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_x           (in_tdata[16:0]),
    .in_y           (in_tdata[48:17]),
    .lr             (lr_r),
    .init_slope     (slope0_r),
    .init_intercept (icpt0_r),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_slope      (slope),
    .out_intercept  (icpt),
    .out_cost       (cost),
    .out_ovf        (out_tuser)
  );

  assign out_tdata = {cost, icpt, slope};
endmodule

// ===== rtl/lrgd_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on lrgd_pkg for the dividend width.
module lrgd_div #(
  parameter int CW = 13
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [lrgd_pkg::SUM_W-1:0]   dividend,
  input  logic [CW-1:0]                divisor,
  output logic [lrgd_pkg::SUM_W-1:0]   quotient,
  output logic                         done
);
  localparam int NW = $clog2(lrgd_pkg::SUM_W);

  logic [lrgd_pkg::SUM_W-1:0] q_r;
  logic [CW-1:0]              rem_r;
  logic [NW-1:0]              cnt_r;
  logic                       busy_r, done_r;
  logic [CW:0]                sh, diff;
  logic                       ge;

  // Trial subtract of the shifted remainder
  always_comb begin
    sh   = {rem_r, q_r[lrgd_pkg::SUM_W-1]};
    ge   = sh >= {1'b0, divisor};
    diff = sh - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + NW'(1);
        if (cnt_r == NW'(lrgd_pkg::SUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift dividend out, quotient in
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? diff[CW-1:0] : sh[CW-1:0];
      q_r   <= {q_r[lrgd_pkg::SUM_W-2:0], ge};
    end
  end

  assign quotient = q_r;
  assign done     = done_r;
endmodule

// ===== rtl/lrgd_ctrl.sv =====
// Sequencer of the regression core: loading, sweeps, divides, updates.
// Depends on lrgd_pkg; drives lrgd_dp through cmd_t.
module lrgd_ctrl (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tlast,
  output logic                         in_tready,
  input  logic [lrgd_pkg::ITER_W-1:0]  iter_cfg,
  input  lrgd_pkg::stat_t              stat,
  output lrgd_pkg::cmd_t               cmd
);
  lrgd_pkg::ctrl_state_t      state_r, state_nxt;
  lrgd_pkg::div_sel_t         sel_r, sel_nxt;
  logic                       cost_r, cost_nxt;
  logic [lrgd_pkg::ITER_W-1:0] iter_r, iter_nxt;
  logic [lrgd_pkg::ITER_W-1:0] iter_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lrgd_pkg::ST_LOAD;
      sel_r   <= lrgd_pkg::SEL_SLOPE;
      cost_r  <= 1'b0;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      cost_r  <= cost_nxt;
      iter_r  <= iter_nxt;
    end
  end

  assign iter_inc = iter_r + lrgd_pkg::ITER_W'(1);

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    cost_nxt    = cost_r;
    iter_nxt    = iter_r;
    cmd         = '0;
    cmd.div_sel = sel_r;
    in_tready   = 1'b0;
    case (state_r)
      lrgd_pkg::ST_LOAD: begin
        // hold off a closing word while the last result waits
        in_tready = !stat.out_busy || !in_tlast;
        if (in_tvalid && in_tready) begin
          cmd.load = 1'b1;
          if (in_tlast) begin
            cmd.init      = 1'b1;
            cmd.sweep_clr = 1'b1;
            iter_nxt      = '0;
            cost_nxt      = (iter_cfg == '0);
            state_nxt     = lrgd_pkg::ST_SWEEP;
          end
        end
      end
      lrgd_pkg::ST_SWEEP: begin
        cmd.rd_en = 1'b1;
        if (stat.rd_last) state_nxt = lrgd_pkg::ST_DRAIN;
      end
      lrgd_pkg::ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          sel_nxt       = cost_r ? lrgd_pkg::SEL_COST : lrgd_pkg::SEL_SLOPE;
          cmd.div_sel   = sel_nxt;
          cmd.div_start = 1'b1;
          state_nxt     = lrgd_pkg::ST_DIV;
        end
      end
      lrgd_pkg::ST_DIV: begin
        if (stat.div_done) begin
          if (sel_r == lrgd_pkg::SEL_COST) begin
            state_nxt = lrgd_pkg::ST_EMIT;
          end else begin
            cmd.mul_start = 1'b1;
            state_nxt     = lrgd_pkg::ST_MUL;
          end
        end
      end
      lrgd_pkg::ST_MUL: begin
        if (stat.mul_done) begin
          if (sel_r == lrgd_pkg::SEL_SLOPE) begin
            cmd.upd_a     = 1'b1;
            sel_nxt       = lrgd_pkg::SEL_INTERCEPT;
            cmd.div_sel   = lrgd_pkg::SEL_INTERCEPT;
            cmd.div_start = 1'b1;
            state_nxt     = lrgd_pkg::ST_DIV;
          end else begin
            cmd.upd_b     = 1'b1;
            iter_nxt      = iter_inc;
            cost_nxt      = (iter_inc == iter_cfg);
            cmd.sweep_clr = 1'b1;
            state_nxt     = lrgd_pkg::ST_SWEEP;
          end
        end
      end
      lrgd_pkg::ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = lrgd_pkg::ST_LOAD;
      end
      default: state_nxt = lrgd_pkg::ST_LOAD;
    endcase
  end
endmodule

// ===== rtl/lrgd_dp.sv =====
// Datapath of the regression core: sample store, residual pipeline,
// gradient sums, shared divider, serial rate multiply, result register.
// Depends on lrgd_pkg and lrgd_div.
module lrgd_dp #(
  parameter int MAX_SAMPLES = lrgd_pkg::MAX_SAMPLES_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  lrgd_pkg::cmd_t                      cmd,
  output lrgd_pkg::stat_t                     stat,
  input  logic [lrgd_pkg::X_W-1:0]            in_x,
  input  logic signed [lrgd_pkg::Y_W-1:0]     in_y,
  input  logic [lrgd_pkg::LR_W-1:0]           lr,
  input  logic signed [lrgd_pkg::COEF_W-1:0]  init_slope,
  input  logic signed [lrgd_pkg::COEF_W-1:0]  init_intercept,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [lrgd_pkg::COEF_W-1:0]  out_slope,
  output logic signed [lrgd_pkg::COEF_W-1:0]  out_intercept,
  output logic [lrgd_pkg::COST_W-1:0]         out_cost,
  output logic                                out_ovf
);
  localparam int AW  = $clog2(MAX_SAMPLES);
  localparam int CW  = $clog2(MAX_SAMPLES + 1);
  localparam int SW  = lrgd_pkg::SUM_W;
  localparam int LW  = lrgd_pkg::LR_W;
  localparam int MW  = SW + 8;
  localparam int MCW = $clog2(LW);

  // Sample store
  logic [lrgd_pkg::X_W-1:0]        xmem [MAX_SAMPLES];
  logic signed [lrgd_pkg::Y_W-1:0] ymem [MAX_SAMPLES];

  logic [CW-1:0] count_r;
  logic          drop_r;
  logic          store_ok;
  logic [AW-1:0] rd_addr_r;

  logic signed [lrgd_pkg::COEF_W-1:0] a_r, b_r;

  // Pipeline registers
  logic                            v1_r, v2_r, v3_r, v4_r;
  logic [lrgd_pkg::X_W-1:0]        x1_r, x2_r, x3_r;
  logic signed [lrgd_pkg::Y_W-1:0] y1_r, y2_r;
  logic signed [48:0]              prod2_r;
  logic signed [34:0]              e3_r, e4_r;
  logic signed [52:0]              ex4_r;
  logic [63:0]                     sq4_r;
  logic                            huge4_r;
  logic signed [33:0]              pred;
  logic [34:0]                     mag;

  logic signed [SW-1:0] ssum_r, isum_r;
  logic [SW-1:0]        csum_r;
  logic                 huge_r;

  // Divide and multiply
  logic [SW-1:0]        dividend, div_q;
  logic                 div_done, neg_r;
  logic signed [SW-1:0] grad;
  logic signed [MW-1:0] mcand_r, macc_r;
  logic [LW-1:0]        mplier_r;
  logic [MCW-1:0]       mul_cnt_r;
  logic                 mul_busy_r, mul_done_r;
  logic signed [57:0]   next_a, next_b;

  logic out_valid_r, ovf_r;
  logic signed [lrgd_pkg::COEF_W-1:0] slope_r, icpt_r;
  logic [lrgd_pkg::COST_W-1:0] cost_r;

  assign store_ok = count_r < CW'(MAX_SAMPLES);

  // Write a word into the store
  always_ff @(posedge clk) begin
    if (cmd.load && store_ok) begin
      xmem[count_r[AW-1:0]] <= in_x;
      ymem[count_r[AW-1:0]] <= in_y;
    end
  end

  // Registered store read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      x1_r <= xmem[rd_addr_r];
      y1_r <= ymem[rd_addr_r];
    end
  end

  // Fill count, drop flag, read address, coefficients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      drop_r    <= 1'b0;
      rd_addr_r <= '0;
      a_r       <= '0;
      b_r       <= '0;
    end else begin
      if (cmd.load) begin
        if (store_ok) count_r <= count_r + CW'(1);
        else drop_r <= 1'b1;
      end
      if (cmd.emit) begin
        count_r <= '0;
        drop_r  <= 1'b0;
      end
      if (cmd.sweep_clr) rd_addr_r <= '0;
      else if (cmd.rd_en) rd_addr_r <= rd_addr_r + AW'(1);
      if (cmd.init) begin
        a_r <= init_slope;
        b_r <= init_intercept;
      end
      if (cmd.upd_a) a_r <= lrgd_pkg::sat32(next_a);
      if (cmd.upd_b) b_r <= lrgd_pkg::sat32(next_b);
    end
  end

  // Valid bits of the residual pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= cmd.rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_comb begin
    pred = 34'($signed(prod2_r[48:16])) + 34'(b_r);
    mag  = e3_r[34] ? 35'(-e3_r) : 35'(e3_r);
  end

  // Prediction, residual, products
  always_ff @(posedge clk) begin
    prod2_r <= a_r * $signed({1'b0, x1_r});
    x2_r    <= x1_r;
    y2_r    <= y1_r;
    e3_r    <= 35'(y2_r) - 35'(pred);
    x3_r    <= x2_r;
    ex4_r   <= e3_r * $signed({1'b0, x3_r});
    sq4_r   <= 64'(mag[31:0]) * 64'(mag[31:0]);
    huge4_r <= |mag[34:32];
    e4_r    <= e3_r;
  end

  // Accumulate gradient and cost sums
  always_ff @(posedge clk) begin
    if (cmd.sweep_clr) begin
      ssum_r <= '0;
      isum_r <= '0;
      csum_r <= '0;
      huge_r <= 1'b0;
    end else if (v4_r) begin
      isum_r <= isum_r - SW'(e4_r);
      ssum_r <= ssum_r - SW'($signed(ex4_r[52:16]));
      csum_r <= csum_r + SW'(sq4_r[63:17]);
      huge_r <= huge_r | huge4_r;
    end
  end

  // Pick the magnitude to divide
  always_comb begin
    case (cmd.div_sel)
      lrgd_pkg::SEL_SLOPE:     dividend = ssum_r[SW-1] ? SW'(-ssum_r) : SW'(ssum_r);
      lrgd_pkg::SEL_INTERCEPT: dividend = isum_r[SW-1] ? SW'(-isum_r) : SW'(isum_r);
      default:                 dividend = csum_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      case (cmd.div_sel)
        lrgd_pkg::SEL_SLOPE:     neg_r <= ssum_r[SW-1];
        lrgd_pkg::SEL_INTERCEPT: neg_r <= isum_r[SW-1];
        default:                 neg_r <= 1'b0;
      endcase
    end
  end

  lrgd_div #(.CW(CW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (count_r),
    .quotient (div_q),
    .done     (div_done)
  );

  // Mean gradient, truncated toward zero
  assign grad = neg_r ? $signed(-div_q) : $signed(div_q);

  // Shift-add multiply of gradient by the rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_busy_r <= 1'b0;
      mul_done_r <= 1'b0;
      mul_cnt_r  <= '0;
    end else begin
      mul_done_r <= 1'b0;
      if (cmd.mul_start) begin
        mul_busy_r <= 1'b1;
        mul_cnt_r  <= '0;
      end else if (mul_busy_r) begin
        mul_cnt_r <= mul_cnt_r + MCW'(1);
        if (mul_cnt_r == MCW'(LW - 1)) begin
          mul_busy_r <= 1'b0;
          mul_done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      mcand_r  <= MW'(grad);
      mplier_r <= lr;
      macc_r   <= '0;
    end else if (mul_busy_r) begin
      if (mplier_r[0]) macc_r <= macc_r + mcand_r;
      mcand_r  <= mcand_r <<< 1;
      mplier_r <= mplier_r >> 1;
    end
  end

  assign next_a = 58'(a_r) - 58'($signed(macc_r[MW-1:16]));
  assign next_b = 58'(b_r) - 58'($signed(macc_r[MW-1:16]));

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.emit) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      slope_r <= a_r;
      icpt_r  <= b_r;
      ovf_r   <= drop_r;
      cost_r  <= (huge_r || (|div_q[SW-1:lrgd_pkg::COST_W])) ? '1
                 : div_q[lrgd_pkg::COST_W-1:0];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_slope     = slope_r;
  assign out_intercept = icpt_r;
  assign out_cost      = cost_r;
  assign out_ovf       = ovf_r;

  always_comb begin
    stat.rd_last   = CW'(rd_addr_r) == (count_r - CW'(1));
    stat.pipe_busy = v1_r | v2_r | v3_r | v4_r;
    stat.div_done  = div_done;
    stat.mul_done  = mul_done_r;
    stat.out_busy  = out_valid_r;
  end
endmodule

// ===== rtl/lrgd_checker.sv =====
// Port-level checks of the regression core, bound to its top level.
// Depends on the core macros header.
`include "linear_regression_gradient_descent_core_macros.svh"

module lrgd_checker (
  input logic clk,
  input logic rst_n,
  input logic in_tvalid,
  input logic in_tready,
  input logic in_tlast,
  input logic out_tvalid,
  input logic out_tready
);
  // A stalled result stays offered
  `LRGD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")
  // Training follows a final word: input closed next cycle
  `LRGD_ASSERT_NEXT(a_train_busy, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready, "input open during training")
  // No result can appear straight after a final word
  `LRGD_ASSERT_NEXT(a_no_early, clk, rst_n, in_tvalid && in_tready && in_tlast, !out_tvalid, "result too early")
  // A final word is never taken while a result waits
  `LRGD_ASSERT_NOW(a_no_overrun, clk, rst_n, out_tvalid && in_tvalid && in_tlast, !in_tready, "final word taken over pending result")
endmodule

bind linear_regression_gradient_descent_core lrgd_checker u_lrgd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
